[rtl/evb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event box classifier package
// Word types, operation codes and sequencer states shared by the interfaces
// and the classifier.
// ----------------------------------------------------------------------------
package evb_pkg;

   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_CLASSIFY = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   localparam int unsigned TOF_SQ_W = 28;
   localparam int unsigned EN_SQ_W  = 24;

   typedef struct packed {
      logic [1:0]  operation;
      logic [2:0]  ion_index;
      logic [5:0]  step_number;
      logic [9:0]  event_tof;
      logic [7:0]  event_energy;
      logic [13:0] tof_center;
      logic [23:0] tof_variance;
      logic [11:0] energy_center;
      logic [19:0] energy_variance;
      logic        clear_after_read;
   } req_word_type;

   typedef struct packed {
      logic        match_found;
      logic [2:0]  matched_ion;
      logic [7:0]  match_mask;
      logic [31:0] count_value;
   } rsp_word_type;

   typedef struct packed {
      logic [13:0] tof_center;
      logic [23:0] tof_variance;
      logic [11:0] energy_center;
      logic [19:0] energy_variance;
   } box_entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CLASSIFY,
      ST_DRAIN,
      ST_READ,
      ST_FINISH
   } state_type;

endpackage

[rtl/evb_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event box classifier request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface evb_req_if import evb_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/evb_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event box classifier response channel
// Valid/ready channel that carries one response word.
// ----------------------------------------------------------------------------
interface evb_rsp_if import evb_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/event_box_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event box classifier
// Matches detector events against per-ion, per-step boxes and keeps
// saturating per-ion, per-step rate counters.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan takes one word per operation: box write, event classify or
//  counter read. rsp_chan returns exactly one word for each request word.
//  csr_wr_en / csr_wr_data set the number of ions checked (reset value 8);
//  write it only while no request is in flight.
//  A box write goes from accept straight to the finish state, a counter
//  read passes the read state first, and a classify issues one ion entry
//  per cycle through the box memory read port, drains the compare pipeline
//  and then finishes; zero ions checked or a step out of range goes
//  straight to finish. A new word is taken only after the previous response
//  is loaded.
//  After reset the block sweeps the counter memory to zero, one entry per
//  cycle, with req_chan.ready low.
//  The response sits in an output register; a stalled receiver holds it and
//  the block keeps working on the next word, waiting only to hand it over.
// ----------------------------------------------------------------------------
module event_box_classifier import evb_pkg::*; #(
   parameter int MAX_IONS  = 8,
   parameter int NUM_STEPS = 64
) (
   input  logic        clock,
   input  logic        reset,
   evb_req_if.sink     req_chan,
   evb_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   localparam int ENTRIES   = MAX_IONS * NUM_STEPS;
   localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ION_LIMIT = (MAX_IONS < 8) ? MAX_IONS : 8;

   // memories
   box_entry_type     box_mem [ENTRIES];
   logic [31:0]       cnt_mem [ENTRIES];

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [3:0]        ions_ff;
   logic [2:0]        issue_ion_ff, issue_ion_in;

   logic [ADDR_W-1:0] addr_ff;
   logic              addr_ok_ff;
   logic              clear_ff;
   logic [5:0]        step_ff;
   logic [9:0]        tof_ff;
   logic [7:0]        energy_ff;

   box_entry_type     box_rd_ff;
   logic [31:0]       cnt_rd_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        s1_ion_ff;
   logic [ADDR_W-1:0] s1_addr_ff;

   logic              s2_valid_ff;
   logic [2:0]        s2_ion_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [TOF_SQ_W-1:0] tof_sq_ff;
   logic [EN_SQ_W-1:0]  en_sq_ff;
   logic [23:0]       tof_var_ff;
   logic [19:0]       en_var_ff;
   logic [31:0]       s2_cnt_ff;

   logic              found_ff;
   logic [2:0]        last_ff;
   logic [7:0]        mask_ff;
   logic [31:0]       count_ff;

   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;

   logic              accept, finish_load, count_load;
   logic              box_we, cnt_we;
   logic [ADDR_W-1:0] rd_addr, cnt_waddr, req_addr, issue_addr;
   logic [31:0]       cnt_wdata, cnt_sat;
   logic              req_step_ok, req_addr_ok, s2_match;
   logic [3:0]        n_eff;
   logic [2:0]        n_last;
   logic signed [14:0] tof_diff;
   logic signed [12:0] en_diff;
   logic signed [29:0] tof_prod;
   logic signed [25:0] en_prod;

   assign req_step_ok = (32'(req_chan.data.step_number) < NUM_STEPS);
   assign req_addr_ok = req_step_ok && (32'(req_chan.data.ion_index) < MAX_IONS);
   assign req_addr    = ADDR_W'(32'(req_chan.data.ion_index) * NUM_STEPS
                                + 32'(req_chan.data.step_number));
   assign issue_addr  = ADDR_W'(32'(issue_ion_ff) * NUM_STEPS + 32'(step_ff));
   assign n_eff       = (ions_ff > 4'(ION_LIMIT)) ? 4'(ION_LIMIT) : ions_ff;
   assign n_last      = 3'(n_eff - 4'd1);

   assign tof_diff = $signed({1'b0, tof_ff, 4'b0000}) - $signed({1'b0, box_rd_ff.tof_center});
   assign en_diff  = $signed({1'b0, energy_ff, 4'b0000})
                   - $signed({1'b0, box_rd_ff.energy_center});
   assign tof_prod = tof_diff * tof_diff;
   assign en_prod  = en_diff * en_diff;

   assign s2_match = s2_valid_ff && (tof_sq_ff <= {4'b0000, tof_var_ff})
                     && (en_sq_ff <= {4'b0000, en_var_ff});
   assign cnt_sat  = (s2_cnt_ff == 32'hFFFF_FFFF) ? s2_cnt_ff : s2_cnt_ff + 32'd1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      issue_ion_in = issue_ion_ff;
      s1_valid_in  = 1'b0;
      req_chan.ready = 1'b0;
      accept       = 1'b0;
      finish_load  = 1'b0;
      count_load   = 1'b0;
      box_we       = 1'b0;
      cnt_we       = 1'b0;
      cnt_waddr    = clr_ff;
      cnt_wdata    = '0;
      rd_addr      = req_addr;
      case (state_ff)
         ST_CLEAR: begin
            cnt_we = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               accept = 1'b1;
               case (req_chan.data.operation)
                  OP_WRITE: begin
                     box_we   = req_addr_ok;
                     state_in = ST_FINISH;
                  end
                  OP_CLASSIFY: begin
                     issue_ion_in = '0;
                     if (req_step_ok && n_eff != 4'd0) begin
                        state_in = ST_CLASSIFY;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_CLASSIFY: begin
            rd_addr      = issue_addr;
            s1_valid_in  = 1'b1;
            issue_ion_in = issue_ion_ff + 3'd1;
            if (issue_ion_ff == n_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            count_load = 1'b1;
            if (addr_ok_ff && clear_ff) begin
               cnt_we    = 1'b1;
               cnt_waddr = addr_ff;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               finish_load = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (s2_match) begin
         cnt_we    = 1'b1;
         cnt_waddr = s2_addr_ff;
         cnt_wdata = cnt_sat;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ions_ff      <= 4'd8;
         issue_ion_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issue_ion_ff <= issue_ion_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         if (csr_wr_en) begin
            ions_ff <= csr_wr_data;
         end
         if (finish_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // memories: one read port each, registered
   always_ff @(posedge clock) begin
      box_rd_ff <= box_mem[rd_addr];
      cnt_rd_ff <= cnt_mem[rd_addr];
      if (box_we) begin
         box_mem[req_addr] <= '{tof_center:      req_chan.data.tof_center,
                                tof_variance:    req_chan.data.tof_variance,
                                energy_center:   req_chan.data.energy_center,
                                energy_variance: req_chan.data.energy_variance};
      end
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff    <= req_addr;
         addr_ok_ff <= req_addr_ok;
         clear_ff   <= req_chan.data.clear_after_read;
         step_ff    <= req_chan.data.step_number;
         tof_ff     <= req_chan.data.event_tof;
         energy_ff  <= req_chan.data.event_energy;
         found_ff   <= 1'b0;
         last_ff    <= '0;
         mask_ff    <= '0;
         count_ff   <= '0;
      end else begin
         if (s2_match) begin
            found_ff <= 1'b1;
            last_ff  <= s2_ion_ff;
            mask_ff  <= mask_ff | (8'd1 << s2_ion_ff);
         end
         if (count_load) begin
            count_ff <= addr_ok_ff ? cnt_rd_ff : 32'd0;
         end
      end
      s1_ion_ff  <= issue_ion_ff;
      s1_addr_ff <= issue_addr;
      s2_ion_ff  <= s1_ion_ff;
      s2_addr_ff <= s1_addr_ff;
      tof_sq_ff  <= TOF_SQ_W'(tof_prod);
      en_sq_ff   <= EN_SQ_W'(en_prod);
      tof_var_ff <= box_rd_ff.tof_variance;
      en_var_ff  <= box_rd_ff.energy_variance;
      s2_cnt_ff  <= cnt_rd_ff;
      if (finish_load) begin
         rsp_word_ff <= '{match_found: found_ff, matched_ion: last_ff,
                          match_mask: mask_ff, count_value: count_ff};
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   // checks
   a_found_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.match_found == (rsp_word_ff.match_mask != 8'd0)))
      else $error("match_found disagrees with match_mask");

   a_last_in_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.match_found)
      |-> rsp_word_ff.match_mask[rsp_word_ff.matched_ion])
      else $error("matched_ion not set in match_mask");

   a_pipe_state: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (state_ff == ST_CLASSIFY || state_ff == ST_DRAIN))
      else $error("compare stage busy outside classify");

   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLASSIFY) |-> ({1'b0, issue_ion_ff} < n_eff))
      else $error("ion issue index beyond ions in use");

endmodule
